@@ sv/lie_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_pkg: shared constants and types of the link impairment emulator
// Queue sizing, operation and CSR codes, the slot entry and the xorshift32 step.
// ----------------------------------------------------------------------------
package lie_pkg;
   localparam int QUEUE_DEPTH  = 16;
   localparam int PAYLOAD_BITS = 64;
   localparam int SLOT_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_BITS     = 3;

   typedef enum logic [1:0] {
      OP_SEND    = 2'd0,
      OP_ADVANCE = 2'd1,
      OP_RECEIVE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_LOSS     = 3'd0,
      CSR_DUP      = 3'd1,
      CSR_REORDER  = 3'd2,
      CSR_LATENCY  = 3'd3,
      CSR_JITTER   = 3'd4,
      CSR_REXTRA   = 3'd5,
      CSR_SEED     = 3'd6,
      CSR_UNUSED   = 3'd7
   } csr_type;

   // one slot entry as stored in the queue memory
   typedef struct packed {
      logic [63:0]             due;
      logic [63:0]             order;
      logic [PAYLOAD_BITS-1:0] payload;
   } slot_type;

   // xorshift32 step with shifts 13, 17, 5
   function automatic logic [31:0] xs_next(input logic [31:0] s);
      logic [31:0] v;
      v = s ^ (s << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction
endpackage

@@ sv/lie_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_divider: bit-serial 32 by 17 bit remainder unit
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lie_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [16:0] remainder
);
   import lie_pkg::*;

   logic [31:0] num_ff, num_in;
   logic [17:0] rem_ff, rem_in;
   logic [16:0] div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;

   // one restoring step per cycle
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[16:0], num_ff[31]};
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[30:0], 1'b0};
         if (trial >= {1'b0, div_ff}) rem_in = trial - {1'b0, div_ff};
         else rem_in = trial;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[16:0];
endmodule

@@ sv/lie_slot_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_slot_ram: queue slot memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module lie_slot_ram (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [lie_pkg::SLOT_BITS-1:0] wr_addr,
   input  lie_pkg::slot_type        wr_data,
   input  logic [lie_pkg::SLOT_BITS-1:0] rd_addr,
   output lie_pkg::slot_type        rd_data
);
   import lie_pkg::*;

   slot_type mem [QUEUE_DEPTH];
   slot_type rd_ff;

   // synchronous write and read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

@@ sv/link_impairment_emulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_impairment_emulator: one-channel packet impairment emulator
// Loss, jitter, reorder and duplication on a 16-slot delivery queue.
// ----------------------------------------------------------------------------
// One beat at a time. Advance, idle and lost sends pass through dispatch and
// done. A receive scans the slot memory through its single read port, an
// address step then a compare step per entry (address, then compare), then
// delivers the pick. A send writes one copy, one more for a duplicate copy,
// and with jitter on each copy first waits for the bit-serial remainder unit.
// The result sits in an output register; the next beat is accepted no earlier
// than the edge at which the result is taken.
module link_impairment_emulator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_payload,
   input  logic [15:0] req_tick_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_delivered,
   output logic [63:0] rsp_delivered_payload,
   output logic        rsp_was_dropped,
   output logic        rsp_was_duplicated,
   output logic [31:0] rsp_sent_count,
   output logic [31:0] rsp_dropped_count,
   output logic [31:0] rsp_duplicated_count,
   output logic [31:0] rsp_reordered_count,
   output logic [31:0] rsp_delivered_count,
   output logic [31:0] rsp_overflow_count,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [32:0] csr_data
);
   import lie_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_JIT_START, S_JIT_WAIT, S_COPY, S_SCAN, S_SCAN_LAST,
      S_PICK, S_DONE, S_OUT
   } state_type;

   // configuration registers
   logic [32:0] loss_ff, dup_ff, reo_ff;
   logic [15:0] lat_ff, jit_ff, rextra_ff;
   logic [31:0] gen_ff;

   state_type   state_ff;
   logic [1:0]  op_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [15:0] ticks_ff;
   logic [63:0] time_ff, ins_ff;
   logic [QUEUE_DEPTH-1:0] valid_ff;
   logic [31:0] cnt_sent_ff, cnt_drop_ff, cnt_dup_ff, cnt_reo_ff, cnt_del_ff,
                cnt_ovf_ff;
   logic        dupcopy_ff, dropped_ff, duplicated_ff;
   logic [CNT_BITS-1:0] scan_ff;
   logic        found_ff;
   logic [SLOT_BITS-1:0] pick_ff, rd_addr_ff;
   logic [63:0] best_due_ff, best_ord_ff;
   logic [PAYLOAD_BITS-1:0] best_pay_ff;
   logic        rsp_valid_ff;
   logic        o_got_ff, o_drop_ff, o_dup_ff;
   logic [63:0] o_pay_ff;

   // queue memory
   logic     wr_en;
   logic [SLOT_BITS-1:0] wr_addr;
   slot_type wr_data, rd_data;
   lie_slot_ram u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr_ff), .rd_data(rd_data)
   );

   // jitter remainder
   logic        div_start, div_done;
   logic [16:0] div_rem;
   lie_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(xs_next(gen_ff)), .divisor({jit_ff, 1'b1}),
      .done(div_done), .remainder(div_rem)
   );

   // draw helper: threshold zero never, 2^32 or more always
   function automatic logic draw_hit(input logic [32:0] t, input logic [31:0] r);
      return t[32] ? 1'b1 : ({1'b0, r} < t);
   endfunction
   function automatic logic draw_adv(input logic [32:0] t);
      return (t != 33'd0) && !t[32];
   endfunction

   // copy delay from the remainder
   logic [16:0] jit_sample_ff;
   logic [17:0] base_sum;
   logic [17:0] base_delay;
   logic [31:0] gen_after_jit;
   logic        reo_hit;
   logic [31:0] gen_after_reo;
   logic [18:0] copy_delay;
   logic        free_any;
   logic [SLOT_BITS-1:0] free_idx;
   logic [31:0] gen_after_dup;
   logic        dup_hit;

   always_comb begin
      base_sum   = {2'b0, lat_ff} + {1'b0, jit_sample_ff};
      if (jit_ff == 16'd0) base_delay = {2'b0, lat_ff};
      else if (base_sum < {2'b0, jit_ff}) base_delay = '0;
      else base_delay = base_sum - {2'b0, jit_ff};
      gen_after_jit = gen_ff;
      reo_hit       = 1'b0;
      if (reo_ff != 33'd0) begin
         reo_hit = draw_hit(reo_ff, xs_next(gen_after_jit));
      end
      gen_after_reo = draw_adv(reo_ff) ? xs_next(gen_after_jit) : gen_after_jit;
      copy_delay = {1'b0, base_delay};
      if (reo_hit) copy_delay = copy_delay + {3'b0, rextra_ff} +
                                {18'b0, ~ins_ff[0]};
      if (dupcopy_ff) copy_delay = copy_delay + 19'd1;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_BITS'(i);
         end
      end
      dup_hit       = 1'b0;
      gen_after_dup = gen_after_reo;
      if (dup_ff != 33'd0) dup_hit = draw_hit(dup_ff, xs_next(gen_after_reo));
      if (draw_adv(dup_ff)) gen_after_dup = xs_next(gen_after_reo);
   end

   // candidate test for the scan
   logic [SLOT_BITS-1:0] cur_idx;
   logic cand, better;
   always_comb begin
      cur_idx = rd_addr_ff;
      cand    = valid_ff[cur_idx] && (rd_data.due <= time_ff);
      better  = !found_ff || (rd_data.due < best_due_ff) ||
                ((rd_data.due == best_due_ff) && (rd_data.order < best_ord_ff));
   end

   assign wr_en     = (state_ff == S_COPY) && free_any;
   assign wr_addr   = free_idx;
   assign wr_data   = '{due: time_ff + {45'b0, copy_delay}, order: ins_ff,
                        payload: pay_ff};
   // divider starts from the generator state left by the previous draws
   assign div_start = (state_ff == S_JIT_START);

   logic loss_hit;
   assign loss_hit = (loss_ff != 33'd0) && draw_hit(loss_ff, xs_next(gen_ff));

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);

   // sequencer
   logic jit_start;
   assign jit_start = (jit_ff != 16'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         loss_ff <= '0; dup_ff <= '0; reo_ff <= '0;
         lat_ff <= '0; jit_ff <= '0; rextra_ff <= '0;
         gen_ff <= 32'd1;
         time_ff <= '0; ins_ff <= '0; valid_ff <= '0;
         cnt_sent_ff <= '0; cnt_drop_ff <= '0; cnt_dup_ff <= '0;
         cnt_reo_ff <= '0; cnt_del_ff <= '0; cnt_ovf_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            case (csr_type'(csr_index))
               CSR_LOSS:    loss_ff   <= csr_data;
               CSR_DUP:     dup_ff    <= csr_data;
               CSR_REORDER: reo_ff    <= csr_data;
               CSR_LATENCY: lat_ff    <= csr_data[15:0];
               CSR_JITTER:  jit_ff    <= csr_data[15:0];
               CSR_REXTRA:  rextra_ff <= csr_data[15:0];
               CSR_SEED:    gen_ff    <= (csr_data[31:0] == 32'd0) ? 32'd1
                                                                   : csr_data[31:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  op_ff    <= req_operation;
                  pay_ff   <= req_payload[PAYLOAD_BITS-1:0];
                  ticks_ff <= req_tick_count;
                  dropped_ff <= 1'b0; duplicated_ff <= 1'b0;
                  dupcopy_ff <= 1'b0; found_ff <= 1'b0;
                  o_got_ff <= 1'b0; o_pay_ff <= '0;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               case (op_type'(op_ff))
                  OP_SEND: begin
                     cnt_sent_ff <= cnt_sent_ff + 32'd1;
                     if (draw_adv(loss_ff)) gen_ff <= xs_next(gen_ff);
                     if (loss_hit) begin
                        cnt_drop_ff <= cnt_drop_ff + 32'd1;
                        dropped_ff  <= 1'b1;
                        state_ff    <= S_DONE;
                     end else if (jit_start) state_ff <= S_JIT_START;
                     else state_ff <= S_COPY;
                  end
                  OP_ADVANCE: begin
                     time_ff  <= time_ff + {48'b0, ticks_ff};
                     state_ff <= S_DONE;
                  end
                  OP_RECEIVE: begin
                     rd_addr_ff <= '0;
                     scan_ff    <= '0;
                     state_ff   <= S_SCAN;
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_JIT_START: begin
               state_ff <= S_JIT_WAIT;
            end
            S_JIT_WAIT: begin
               if (div_done) begin
                  jit_sample_ff <= div_rem;
                  gen_ff   <= xs_next(gen_ff);
                  state_ff <= S_COPY;
               end
            end
            S_COPY: begin
               if (reo_hit) cnt_reo_ff <= cnt_reo_ff + 32'd1;
               if (free_any) valid_ff[free_idx] <= 1'b1;
               else cnt_ovf_ff <= cnt_ovf_ff + 32'd1;
               ins_ff <= ins_ff + 64'd1;
               // duplication draw follows the first copy only
               if (!dupcopy_ff && dup_hit) begin
                  gen_ff        <= gen_after_dup;
                  cnt_dup_ff    <= cnt_dup_ff + 32'd1;
                  duplicated_ff <= 1'b1;
                  dupcopy_ff    <= 1'b1;
                  state_ff      <= jit_start ? S_JIT_START : S_COPY;
               end else begin
                  gen_ff   <= dupcopy_ff ? gen_after_reo : gen_after_dup;
                  state_ff <= S_DONE;
               end
            end
            S_SCAN: begin
               // address issued; data arrives next cycle
               if (scan_ff == CNT_BITS'(QUEUE_DEPTH - 1)) state_ff <= S_SCAN_LAST;
               else begin
                  scan_ff  <= scan_ff + CNT_BITS'(1);
                  state_ff <= S_PICK;
               end
            end
            S_PICK, S_SCAN_LAST: begin
               // compare the entry read for the current address
               if (cand && better) begin
                  found_ff    <= 1'b1;
                  pick_ff     <= cur_idx;
                  best_due_ff <= rd_data.due;
                  best_ord_ff <= rd_data.order;
                  best_pay_ff <= rd_data.payload;
               end
               if (state_ff == S_PICK) begin
                  rd_addr_ff <= rd_addr_ff + SLOT_BITS'(1);
                  state_ff   <= S_SCAN;
               end else state_ff <= S_OUT;
            end
            S_OUT: begin
               if (found_ff) begin
                  valid_ff[pick_ff] <= 1'b0;
                  cnt_del_ff <= cnt_del_ff + 32'd1;
                  o_got_ff   <= 1'b1;
                  o_pay_ff   <= 64'(best_pay_ff);
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  o_drop_ff <= dropped_ff;
                  o_dup_ff  <= duplicated_ff;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_delivered         = o_got_ff;
   assign rsp_delivered_payload = o_pay_ff;
   assign rsp_was_dropped       = o_drop_ff;
   assign rsp_was_duplicated    = o_dup_ff;
   assign rsp_sent_count        = cnt_sent_ff;
   assign rsp_dropped_count     = cnt_drop_ff;
   assign rsp_duplicated_count  = cnt_dup_ff;
   assign rsp_reordered_count   = cnt_reo_ff;
   assign rsp_delivered_count   = cnt_del_ff;
   assign rsp_overflow_count    = cnt_ovf_ff;
endmodule

@@ sv/lie_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_checker: port-level checks of the link impairment emulator
// Watches the result handshake, the send total and the result flags.
// ----------------------------------------------------------------------------
module lie_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_delivered,
   input logic        rsp_was_dropped,
   input logic [63:0] rsp_delivered_payload,
   input logic [31:0] rsp_sent_count
);
   import lie_pkg::*;

   // a stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_delivered_payload))
      else $error("stalled result changed");

   // the send total of a stalled result beat holds
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_sent_count))
      else $error("stalled send total changed");

   // delivery and loss never flag together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_delivered && rsp_was_dropped))
      else $error("delivered and dropped together");

   // no payload without a delivery
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_delivered |-> rsp_delivered_payload == 64'd0)
      else $error("payload without delivery");
endmodule

bind link_impairment_emulator lie_checker u_lie_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_delivered(rsp_delivered), .rsp_was_dropped(rsp_was_dropped),
   .rsp_delivered_payload(rsp_delivered_payload), .rsp_sent_count(rsp_sent_count)
);
